// ===== hw/rtl/gkg_pkg.sv =====
// Shared widths, stage numbers, register codes and types of the kernel gradient block.
`timescale 1ns / 1ps
`default_nettype none
package gkg_pkg;

  localparam int MAX_SOURCES = 4;
  localparam int LANES       = MAX_SOURCES;
  localparam int CNT_W       = 3;

  // Number formats along the datapath.
  localparam int SMP_W  = 16;               // Q3.12 source value
  localparam int DIFF_W = SMP_W + 1;        // Q4.12 difference
  localparam int W_W    = 16;               // Q1.14 weight
  localparam int PROD_W = W_W + DIFF_W;     // one lane term of the dot product
  localparam int DOT_W  = 34;               // sum of all lane terms
  localparam int KV_W   = 16;               // Q1.15 kernel entry
  localparam int DK_W   = 50;               // dot times kernel entry
  localparam int S1_SH  = 25;
  localparam int S1_W   = 26;
  localparam int NIS_W  = 24;               // Q7.16 scale
  localparam int S1N_W  = S1_W + NIS_W;
  localparam int S2_SH  = 16;
  localparam int S2_W   = 34;
  localparam int P2_W   = DIFF_W + S2_W;
  localparam int OUT_SH = 12;
  localparam int R_W    = P2_W + 1 - OUT_SH;
  localparam int OUT_W  = 32;

  // Pipeline stage numbers.
  localparam int ST_DIFF = 0;
  localparam int ST_PROD = 1;
  localparam int ST_DOT  = 2;
  localparam int ST_DK   = 3;
  localparam int ST_S1N  = 4;
  localparam int ST_P2   = 5;
  localparam int ST_OUT  = 6;
  localparam int STAGES  = 7;

  // Register port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] SOURCE_COUNT_RST = CNT_W'(MAX_SOURCES);
  localparam logic [NIS_W-1:0] NIS_RST          = 24'hFF0000;

  typedef enum logic [2:0] {
    REG_SOURCE_COUNT     = 3'd0,
    REG_WEIGHT_0         = 3'd1,
    REG_WEIGHT_1         = 3'd2,
    REG_WEIGHT_2         = 3'd3,
    REG_WEIGHT_3         = 3'd4,
    REG_NEG_INV_SIGMA_SQ = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]            source_count;
    logic [LANES-1:0][W_W-1:0]   weight;
    logic [NIS_W-1:0]            neg_inv_sigma_sq;
  } cfg_t;

  typedef struct packed {
    logic [STAGES-1:0] en;
    logic              active;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gkg_if.sv =====
// Request and result channel interfaces of the kernel gradient block.
`timescale 1ns / 1ps
`default_nettype none
interface gkg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gkg_pkg::SMP_W-1:0]    sample_0;
  logic signed [gkg_pkg::SMP_W-1:0]    sample_1;
  logic signed [gkg_pkg::SMP_W-1:0]    sample_2;
  logic signed [gkg_pkg::SMP_W-1:0]    sample_3;
  logic signed [gkg_pkg::SMP_W-1:0]    pivot_0;
  logic signed [gkg_pkg::SMP_W-1:0]    pivot_1;
  logic signed [gkg_pkg::SMP_W-1:0]    pivot_2;
  logic signed [gkg_pkg::SMP_W-1:0]    pivot_3;
  logic        [gkg_pkg::KV_W-1:0]     kernel_value;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                  pivot_0, pivot_1, pivot_2, pivot_3, kernel_value,
                  input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                  pivot_0, pivot_1, pivot_2, pivot_3, kernel_value,
                  output ready);
endinterface

interface gkg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gkg_pkg::OUT_W-1:0]    deriv_0;
  logic signed [gkg_pkg::OUT_W-1:0]    deriv_1;
  logic signed [gkg_pkg::OUT_W-1:0]    deriv_2;
  logic signed [gkg_pkg::OUT_W-1:0]    deriv_3;
  logic                                saturated;

  modport source (output valid, deriv_0, deriv_1, deriv_2, deriv_3, saturated,
                  input ready);
  modport sink   (input valid, deriv_0, deriv_1, deriv_2, deriv_3, saturated,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gkg_regs.sv =====
// APB register file holding the lane count, weight row and kernel scale.
`timescale 1ns / 1ps
`default_nettype none
module gkg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gkg_pkg::ADDR_W-1:0]    paddr,
  input  logic [gkg_pkg::DATA_W-1:0]    pwdata,
  output logic [gkg_pkg::DATA_W-1:0]    prdata,
  output gkg_pkg::cfg_t                 cfg
);

  gkg_pkg::reg_idx_t idx;
  logic              wr;

  assign idx = gkg_pkg::reg_idx_t'(paddr[gkg_pkg::ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_count     <= gkg_pkg::SOURCE_COUNT_RST;
      cfg.weight           <= '0;
      cfg.neg_inv_sigma_sq <= gkg_pkg::NIS_RST;
    end else if (wr) begin
      unique case (idx)
        gkg_pkg::REG_SOURCE_COUNT:
          cfg.source_count <= pwdata[gkg_pkg::CNT_W-1:0];
        gkg_pkg::REG_WEIGHT_0: cfg.weight[0] <= pwdata[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_WEIGHT_1: cfg.weight[1] <= pwdata[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_WEIGHT_2: cfg.weight[2] <= pwdata[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_WEIGHT_3: cfg.weight[3] <= pwdata[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_NEG_INV_SIGMA_SQ:
          cfg.neg_inv_sigma_sq <= pwdata[gkg_pkg::NIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gkg_pkg::REG_SOURCE_COUNT:
        prdata = gkg_pkg::DATA_W'(cfg.source_count);
      gkg_pkg::REG_WEIGHT_0: prdata = gkg_pkg::DATA_W'($signed(cfg.weight[0]));
      gkg_pkg::REG_WEIGHT_1: prdata = gkg_pkg::DATA_W'($signed(cfg.weight[1]));
      gkg_pkg::REG_WEIGHT_2: prdata = gkg_pkg::DATA_W'($signed(cfg.weight[2]));
      gkg_pkg::REG_WEIGHT_3: prdata = gkg_pkg::DATA_W'($signed(cfg.weight[3]));
      gkg_pkg::REG_NEG_INV_SIGMA_SQ:
        prdata = gkg_pkg::DATA_W'($signed(cfg.neg_inv_sigma_sq));
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gkg_lane.sv =====
// One source lane: difference, weighted term, final scaling with saturation.
`timescale 1ns / 1ps
`default_nettype none
module gkg_lane (
  input  logic                                clk,
  input  gkg_pkg::lane_ctl_t                  ctl,
  input  logic signed [gkg_pkg::SMP_W-1:0]    sample,
  input  logic signed [gkg_pkg::SMP_W-1:0]    pivot,
  input  logic signed [gkg_pkg::W_W-1:0]      weight,
  input  logic signed [gkg_pkg::S2_W-1:0]     s2,
  output logic signed [gkg_pkg::PROD_W-1:0]   prod,
  output logic signed [gkg_pkg::OUT_W-1:0]    deriv,
  output logic                                sat
);

  // The difference travels alongside the shared scalar until it is needed again.
  logic signed [gkg_pkg::DIFF_W-1:0] diffq [gkg_pkg::ST_S1N+1];
  logic signed [gkg_pkg::DIFF_W-1:0] diff_next;
  logic signed [gkg_pkg::PROD_W-1:0] prod_next;
  logic signed [gkg_pkg::P2_W-1:0]   p2;
  logic signed [gkg_pkg::P2_W-1:0]   p2_next;
  logic        [gkg_pkg::P2_W:0]     rsum;
  logic        [gkg_pkg::R_W-1:0]    r;
  logic                              ovf;
  logic signed [gkg_pkg::OUT_W-1:0]  deriv_next;

  assign diff_next = gkg_pkg::DIFF_W'(sample) - gkg_pkg::DIFF_W'(pivot);
  assign prod_next = ctl.active ?
                     gkg_pkg::PROD_W'(weight) * gkg_pkg::PROD_W'(diffq[gkg_pkg::ST_DIFF]) : '0;
  assign p2_next   = gkg_pkg::P2_W'(diffq[gkg_pkg::ST_S1N]) * gkg_pkg::P2_W'(s2);

  // Round half up, then check that the result fits in 32 bits.
  assign rsum = {p2[gkg_pkg::P2_W-1], p2}
              + ((gkg_pkg::P2_W+1)'(1) << (gkg_pkg::OUT_SH - 1));
  assign r    = rsum[gkg_pkg::P2_W:gkg_pkg::OUT_SH];
  assign ovf  = !((&r[gkg_pkg::R_W-1:gkg_pkg::OUT_W-1]) ||
                  !(|r[gkg_pkg::R_W-1:gkg_pkg::OUT_W-1]));

  always_comb begin
    if (!ctl.active) begin
      deriv_next = '0;
    end else if (!ovf) begin
      deriv_next = r[gkg_pkg::OUT_W-1:0];
    end else if (r[gkg_pkg::R_W-1]) begin
      deriv_next = {1'b1, {(gkg_pkg::OUT_W-1){1'b0}}};
    end else begin
      deriv_next = {1'b0, {(gkg_pkg::OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[gkg_pkg::ST_DIFF]) begin
      diffq[gkg_pkg::ST_DIFF] <= diff_next;
    end
    for (int k = gkg_pkg::ST_DIFF + 1; k <= gkg_pkg::ST_S1N; k++) begin
      if (ctl.en[k]) begin
        diffq[k] <= diffq[k-1];
      end
    end
    if (ctl.en[gkg_pkg::ST_PROD]) begin
      prod <= prod_next;
    end
    if (ctl.en[gkg_pkg::ST_P2]) begin
      p2 <= p2_next;
    end
    if (ctl.en[gkg_pkg::ST_OUT]) begin
      deriv <= deriv_next;
      sat   <= ctl.active && ovf;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gkg_merge.sv =====
// Merging stage: sums the lane terms and forms the shared scalar.
`timescale 1ns / 1ps
`default_nettype none
module gkg_merge (
  input  logic                                clk,
  input  logic [gkg_pkg::STAGES-1:0]          en,
  input  logic signed [gkg_pkg::PROD_W-1:0]   prod [gkg_pkg::LANES],
  input  logic [gkg_pkg::KV_W-1:0]            kernel_value,
  input  logic signed [gkg_pkg::NIS_W-1:0]    neg_inv_sigma_sq,
  output logic signed [gkg_pkg::S2_W-1:0]     s2
);

  logic [gkg_pkg::KV_W-1:0]            kq [gkg_pkg::ST_DOT+1];
  logic signed [gkg_pkg::DOT_W-1:0]    dot;
  logic signed [gkg_pkg::DOT_W-1:0]    dot_next;
  logic signed [gkg_pkg::DK_W:0]       dk_full;
  logic signed [gkg_pkg::DK_W-1:0]     dk;
  logic        [gkg_pkg::DK_W:0]       s1_sum;
  logic signed [gkg_pkg::S1_W-1:0]     s1;
  logic signed [gkg_pkg::S1N_W-1:0]    s1n;
  logic signed [gkg_pkg::S1N_W-1:0]    s1n_next;
  logic        [gkg_pkg::S1N_W:0]      s2_sum;

  always_comb begin
    dot_next = '0;
    for (int i = 0; i < gkg_pkg::LANES; i++) begin
      dot_next = dot_next + gkg_pkg::DOT_W'(prod[i]);
    end
  end

  assign dk_full = (gkg_pkg::DK_W+1)'(dot)
                 * $signed({{(gkg_pkg::DK_W-gkg_pkg::KV_W){1'b0}}, kq[gkg_pkg::ST_DOT]});

  // Both scalar roundings add half an output step before dropping bits.
  assign s1_sum   = {dk[gkg_pkg::DK_W-1], dk}
                  + ((gkg_pkg::DK_W+1)'(1) << (gkg_pkg::S1_SH - 1));
  assign s1       = s1_sum[gkg_pkg::S1_SH+gkg_pkg::S1_W-1:gkg_pkg::S1_SH];
  assign s1n_next = gkg_pkg::S1N_W'(s1) * gkg_pkg::S1N_W'(neg_inv_sigma_sq);
  assign s2_sum   = {s1n[gkg_pkg::S1N_W-1], s1n}
                  + ((gkg_pkg::S1N_W+1)'(1) << (gkg_pkg::S2_SH - 1));
  assign s2       = s2_sum[gkg_pkg::S2_SH+gkg_pkg::S2_W-1:gkg_pkg::S2_SH];

  always_ff @(posedge clk) begin
    if (en[gkg_pkg::ST_DIFF]) begin
      kq[gkg_pkg::ST_DIFF] <= kernel_value;
    end
    for (int k = gkg_pkg::ST_DIFF + 1; k <= gkg_pkg::ST_DOT; k++) begin
      if (en[k]) begin
        kq[k] <= kq[k-1];
      end
    end
    if (en[gkg_pkg::ST_DOT]) begin
      dot <= dot_next;
    end
    if (en[gkg_pkg::ST_DK]) begin
      dk <= dk_full[gkg_pkg::DK_W-1:0];
    end
    if (en[gkg_pkg::ST_S1N]) begin
      s1n <= s1n_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gaussian_kernel_gradient.sv =====
// Top level of the Gaussian kernel gradient block: lanes, merge stage and control.
//
// Usage:
//   pair  : request channel. Each request carries one sample vector, one pivot
//           vector of four source values and the kernel entry for the pair.
//   grad  : result channel. One result per request: four Q15.16 derivatives
//           and a flag that is set when any active lane was clipped.
//   APB   : lane count, weight row and -1/sigma^2. Write only while idle;
//           pready is always high and reads return the register contents.
// The pipeline has seven register stages: difference, weighted term, lane
// sum, kernel product, scale product, lane product, rounding with saturation.
// Throughput is one request per cycle while the receiver takes results;
// every stage has its own valid bit.
// When the receiver stalls, the result holds in the output register and the
// earlier stages keep filling their bubbles; pair.ready falls only once the
// whole pipeline is occupied.
// Reset empties the pipeline and loads the registers with four lanes, zero
// weights and a scale of -1.0.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_kernel_gradient (
  input  logic                          clk,
  input  logic                          rst,
  gkg_in_if.sink                        pair,
  gkg_out_if.source                     grad,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gkg_pkg::ADDR_W-1:0]    paddr,
  input  logic [gkg_pkg::DATA_W-1:0]    pwdata,
  output logic [gkg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  gkg_pkg::cfg_t                      cfg;
  logic [gkg_pkg::STAGES-1:0]         vld;
  logic [gkg_pkg::STAGES-1:0]         rdy;
  logic [gkg_pkg::CNT_W-1:0]          count;
  logic [gkg_pkg::LANES-1:0]          active;
  logic [gkg_pkg::LANES-1:0]          sat;
  logic signed [gkg_pkg::SMP_W-1:0]   smp [gkg_pkg::LANES];
  logic signed [gkg_pkg::SMP_W-1:0]   piv [gkg_pkg::LANES];
  logic signed [gkg_pkg::PROD_W-1:0]  prod [gkg_pkg::LANES];
  logic signed [gkg_pkg::OUT_W-1:0]   deriv [gkg_pkg::LANES];
  logic signed [gkg_pkg::S2_W-1:0]    s2;

  assign pready = 1'b1;

  gkg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // A count above the lane total uses every lane.
  assign count = (cfg.source_count > gkg_pkg::CNT_W'(gkg_pkg::LANES)) ?
                 gkg_pkg::CNT_W'(gkg_pkg::LANES) : cfg.source_count;

  always_comb begin
    for (int i = 0; i < gkg_pkg::LANES; i++) begin
      active[i] = gkg_pkg::CNT_W'(i) < count;
    end
  end

  // A stage may load when it is empty or its successor moves on.
  always_comb begin
    rdy[gkg_pkg::STAGES-1] = !vld[gkg_pkg::STAGES-1] || grad.ready;
    for (int k = gkg_pkg::STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pair.valid;
      end
      for (int k = 1; k < gkg_pkg::STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pair.ready = rdy[0];

  assign smp[0] = pair.sample_0;
  assign smp[1] = pair.sample_1;
  assign smp[2] = pair.sample_2;
  assign smp[3] = pair.sample_3;
  assign piv[0] = pair.pivot_0;
  assign piv[1] = pair.pivot_1;
  assign piv[2] = pair.pivot_2;
  assign piv[3] = pair.pivot_3;

  for (genvar i = 0; i < gkg_pkg::LANES; i++) begin : g_lane
    gkg_pkg::lane_ctl_t ctl;

    assign ctl.en     = rdy;
    assign ctl.active = active[i];

    gkg_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .sample (smp[i]),
      .pivot  (piv[i]),
      .weight ($signed(cfg.weight[i])),
      .s2     (s2),
      .prod   (prod[i]),
      .deriv  (deriv[i]),
      .sat    (sat[i])
    );
  end

  gkg_merge u_merge (
    .clk              (clk),
    .en               (rdy),
    .prod             (prod),
    .kernel_value     (pair.kernel_value),
    .neg_inv_sigma_sq ($signed(cfg.neg_inv_sigma_sq)),
    .s2               (s2)
  );

  assign grad.valid     = vld[gkg_pkg::STAGES-1];
  assign grad.deriv_0   = deriv[0];
  assign grad.deriv_1   = deriv[1];
  assign grad.deriv_2   = deriv[2];
  assign grad.deriv_3   = deriv[3];
  assign grad.saturated = |sat;

endmodule
`default_nettype wire

// ===== hw/rtl/gkg_checker.sv =====
// Port-level checks of the kernel gradient block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gkg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               pair_valid,
  input logic                               pair_ready,
  input logic                               grad_valid,
  input logic                               grad_ready,
  input logic signed [gkg_pkg::OUT_W-1:0]   deriv_0,
  input logic signed [gkg_pkg::OUT_W-1:0]   deriv_1,
  input logic signed [gkg_pkg::OUT_W-1:0]   deriv_2,
  input logic signed [gkg_pkg::OUT_W-1:0]   deriv_3,
  input logic                               saturated
);

  localparam logic [gkg_pkg::OUT_W-1:0] POS_MAX = {1'b0, {(gkg_pkg::OUT_W-1){1'b1}}};
  localparam logic [gkg_pkg::OUT_W-1:0] NEG_MAX = {1'b1, {(gkg_pkg::OUT_W-1){1'b0}}};

  // A reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !grad_valid)
    else $error("result valid right after reset");

  // With the output free, the pipeline can always take a request.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!grad_valid || grad_ready) |-> pair_ready)
    else $error("request refused while the pipeline could advance");

  // A clipped result shows a full-scale value in some lane.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (grad_valid && saturated) |->
      (deriv_0 == POS_MAX || deriv_0 == NEG_MAX || deriv_1 == POS_MAX ||
       deriv_1 == NEG_MAX || deriv_2 == POS_MAX || deriv_2 == NEG_MAX ||
       deriv_3 == POS_MAX || deriv_3 == NEG_MAX))
    else $error("saturated flag without a full-scale lane value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (grad_valid && !grad_ready) |=>
      (grad_valid && $stable(deriv_0) && $stable(deriv_3) && $stable(saturated)))
    else $error("stalled result changed");

endmodule

bind gaussian_kernel_gradient gkg_checker u_gkg_checker (
  .clk        (clk),
  .rst        (rst),
  .pair_valid (pair.valid),
  .pair_ready (pair.ready),
  .grad_valid (grad.valid),
  .grad_ready (grad.ready),
  .deriv_0    (grad.deriv_0),
  .deriv_1    (grad.deriv_1),
  .deriv_2    (grad.deriv_2),
  .deriv_3    (grad.deriv_3),
  .saturated  (grad.saturated)
);
`default_nettype wire

// ===== sim/tb_gaussian_kernel_gradient.sv =====
// Self-checking testbench for the Gaussian kernel gradient block.
`timescale 1ns / 1ps
module tb_gaussian_kernel_gradient;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = gkg_pkg::STAGES + 2;
  localparam int SET_ITEMS   = 54;
  localparam int REG_UNMAPPED = int'(gkg_pkg::REG_NEG_INV_SIGMA_SQ) + 1;

  typedef struct packed {
    logic [gkg_pkg::LANES-1:0][gkg_pkg::SMP_W-1:0] sample;
    logic [gkg_pkg::LANES-1:0][gkg_pkg::SMP_W-1:0] pivot;
    logic [gkg_pkg::KV_W-1:0]                      kernel_value;
  } pair_t;

  typedef struct packed {
    logic [gkg_pkg::LANES-1:0][gkg_pkg::OUT_W-1:0] deriv;
    logic                                          saturated;
  } grad_t;

  // Holds a copy of the register file and the derivatives still owed by the block.
  class grad_scoreboard;
    gkg_pkg::cfg_t cfg;
    grad_t         expected_q[$];
    int            errors;

    function new();
      cfg.source_count     = gkg_pkg::SOURCE_COUNT_RST;
      cfg.weight           = '0;
      cfg.neg_inv_sigma_sq = gkg_pkg::NIS_RST;
      errors               = 0;
    endfunction

    function void set_register(int idx, logic [gkg_pkg::DATA_W-1:0] value);
      case (idx)
        gkg_pkg::REG_SOURCE_COUNT:
          cfg.source_count = value[gkg_pkg::CNT_W-1:0];
        gkg_pkg::REG_WEIGHT_0: cfg.weight[0] = value[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_WEIGHT_1: cfg.weight[1] = value[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_WEIGHT_2: cfg.weight[2] = value[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_WEIGHT_3: cfg.weight[3] = value[gkg_pkg::W_W-1:0];
        gkg_pkg::REG_NEG_INV_SIGMA_SQ:
          cfg.neg_inv_sigma_sq = value[gkg_pkg::NIS_W-1:0];
        default: ;
      endcase
    endfunction

    // Add half, then floor shift.
    function longint round_q(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function void note_request(pair_t p);
      longint diff[gkg_pkg::LANES];
      longint dot, s1, s2, lane;
      int     active;
      grad_t  g;
      dot = 0;
      g = '0;
      active = (cfg.source_count > gkg_pkg::MAX_SOURCES) ?
               gkg_pkg::MAX_SOURCES : int'(cfg.source_count);
      for (int i = 0; i < gkg_pkg::LANES; i++) begin
        diff[i] = longint'($signed(p.sample[i])) - longint'($signed(p.pivot[i]));
        if (i < active) dot += longint'($signed(cfg.weight[i])) * diff[i];
      end
      s1 = round_q(dot * longint'(p.kernel_value), gkg_pkg::S1_SH);
      s2 = round_q(s1 * longint'($signed(cfg.neg_inv_sigma_sq)), gkg_pkg::S2_SH);
      for (int i = 0; i < active; i++) begin
        lane = round_q(diff[i] * s2, gkg_pkg::OUT_SH);
        if (lane > 64'sd2147483647) begin
          lane = 64'sd2147483647;
          g.saturated = 1'b1;
        end else if (lane < -64'sd2147483648) begin
          lane = -64'sd2147483648;
          g.saturated = 1'b1;
        end
        g.deriv[i] = lane[gkg_pkg::OUT_W-1:0];
      end
      expected_q.push_back(g);
    endfunction

    function void check_result(grad_t got);
      grad_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: deriv %h saturated %b",
                 $time, got.deriv, got.saturated);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < gkg_pkg::LANES; i++) begin
        if (got.deriv[i] !== want.deriv[i]) begin
          $display("%0t: deriv_%0d expected %0d, got %0d", $time, i,
                   $signed(want.deriv[i]), $signed(got.deriv[i]));
          errors++;
        end
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b, got %b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [gkg_pkg::ADDR_W-1:0] paddr;
  logic [gkg_pkg::DATA_W-1:0] pwdata;
  logic [gkg_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int send_idle_pct;
  int recv_stall_pct;

  grad_scoreboard board;

  gkg_in_if  pair_ch ();
  gkg_out_if grad_ch ();

  gaussian_kernel_gradient dut (
    .clk     (clk),
    .rst     (rst),
    .pair    (pair_ch),
    .grad    (grad_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Result side: check what was accepted at this edge, then pick the next ready.
  always @(posedge clk) begin : result_sink
    grad_t got;
    if (!rst && grad_ch.valid && grad_ch.ready) begin
      got.deriv[0]  = grad_ch.deriv_0;
      got.deriv[1]  = grad_ch.deriv_1;
      got.deriv[2]  = grad_ch.deriv_2;
      got.deriv[3]  = grad_ch.deriv_3;
      got.saturated = grad_ch.saturated;
      board.check_result(got);
    end
    grad_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pair_ch.valid && pair_ch.ready) || (grad_ch.valid && grad_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_pair(pair_t p);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pair_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pair_ch.valid        <= 1'b1;
    pair_ch.sample_0     <= p.sample[0];
    pair_ch.sample_1     <= p.sample[1];
    pair_ch.sample_2     <= p.sample[2];
    pair_ch.sample_3     <= p.sample[3];
    pair_ch.pivot_0      <= p.pivot[0];
    pair_ch.pivot_1      <= p.pivot[1];
    pair_ch.pivot_2      <= p.pivot[2];
    pair_ch.pivot_3      <= p.pivot[3];
    pair_ch.kernel_value <= p.kernel_value;
    do @(posedge clk); while (!pair_ch.ready);
    board.note_request(p);
  endtask

  // Stop sending and let every request come out of the pipeline.
  task automatic drain();
    pair_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [gkg_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gkg_pkg::ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [gkg_pkg::CNT_W-1:0] count,
                            logic [gkg_pkg::LANES-1:0][gkg_pkg::W_W-1:0] w,
                            logic [gkg_pkg::NIS_W-1:0] scale);
    localparam int WPAD = gkg_pkg::DATA_W - gkg_pkg::W_W;
    localparam int NPAD = gkg_pkg::DATA_W - gkg_pkg::NIS_W;
    drain();
    write_reg(gkg_pkg::REG_SOURCE_COUNT, gkg_pkg::DATA_W'(count));
    write_reg(gkg_pkg::REG_WEIGHT_0, {{WPAD{w[0][gkg_pkg::W_W-1]}}, w[0]});
    write_reg(gkg_pkg::REG_WEIGHT_1, {{WPAD{w[1][gkg_pkg::W_W-1]}}, w[1]});
    write_reg(gkg_pkg::REG_WEIGHT_2, {{WPAD{w[2][gkg_pkg::W_W-1]}}, w[2]});
    write_reg(gkg_pkg::REG_WEIGHT_3, {{WPAD{w[3][gkg_pkg::W_W-1]}}, w[3]});
    write_reg(gkg_pkg::REG_NEG_INV_SIGMA_SQ,
              {{NPAD{scale[gkg_pkg::NIS_W-1]}}, scale});
  endtask

  function automatic pair_t make_pair(
      logic [gkg_pkg::LANES-1:0][gkg_pkg::SMP_W-1:0] smp,
      logic [gkg_pkg::LANES-1:0][gkg_pkg::SMP_W-1:0] pvt,
      logic [gkg_pkg::KV_W-1:0] kv);
    pair_t p;
    p.sample       = smp;
    p.pivot        = pvt;
    p.kernel_value = kv;
    return p;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($urandom_range(2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    for (int i = 0; i < gkg_pkg::LANES; i++) begin
      p.sample[i] = pick_word();
      p.pivot[i]  = pick_word();
    end
    case ($urandom_range(9))
      0: p.kernel_value = 16'h0000;
      1: p.kernel_value = 16'h8000;
      2: p.kernel_value = 16'($urandom);
      default: p.kernel_value = 16'($urandom_range(32768));
    endcase
    return p;
  endfunction

  task automatic random_config();
    logic [gkg_pkg::CNT_W-1:0]                   count;
    logic [gkg_pkg::LANES-1:0][gkg_pkg::W_W-1:0] w;
    logic [gkg_pkg::NIS_W-1:0]                   scale;
    case ($urandom_range(9))
      0: count = '0;
      1: count = gkg_pkg::CNT_W'($urandom_range(7, 5));
      default: count = gkg_pkg::CNT_W'($urandom_range(4, 1));
    endcase
    for (int i = 0; i < gkg_pkg::LANES; i++) w[i] = pick_word();
    case ($urandom_range(9))
      0: scale = gkg_pkg::NIS_RST;
      1: scale = 24'h800000;
      2: scale = 24'h000000;
      3: scale = {1'b0, 23'($urandom)};
      4, 5: scale = 24'(-int'($urandom_range(262144)));
      default: scale = {1'b1, 23'($urandom)};
    endcase
    set_config(count, w, scale);
    // Writes outside the register map must leave everything unchanged.
    if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED + $urandom_range(1), $urandom);
  endtask

  initial begin
    board                = new();
    clk                  = 1'b0;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    grad_ch.ready        = 1'b0;
    pair_ch.valid        = 1'b0;
    pair_ch.sample_0     = '0;
    pair_ch.sample_1     = '0;
    pair_ch.sample_2     = '0;
    pair_ch.sample_3     = '0;
    pair_ch.pivot_0      = '0;
    pair_ch.pivot_1      = '0;
    pair_ch.pivot_2      = '0;
    pair_ch.pivot_3      = '0;
    pair_ch.kernel_value = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset weights are zero, so even the widest differences give zero.
    send_pair(make_pair({4{16'h7FFF}}, {4{16'h8000}}, 16'h8000));

    // Largest weights and scale: the widest differences clip in both directions.
    set_config(3'd4, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 24'h800000);
    send_pair(make_pair({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                        {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000));
    send_pair(make_pair({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                        {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'hFFFF));
    send_pair(make_pair({4{16'h7FFF}}, {4{16'h8000}}, 16'h0000));
    send_pair(make_pair({4{16'h1234}}, {4{16'h1234}}, 16'h8000));
    send_pair(make_pair({16'h0100, 16'hFFF0, 16'h0020, 16'h0010}, '0, 16'h8000));
    send_pair(make_pair({4{16'h8000}}, {4{16'h7FFF}}, 16'h4000));

    // No lanes in use: everything reads back zero.
    set_config(3'd0, {4{16'h7FFF}}, 24'h800000);
    send_pair(make_pair({4{16'h7FFF}}, {4{16'h8000}}, 16'h8000));
    send_pair(make_pair({4{16'h8000}}, {4{16'h7FFF}}, 16'hFFFF));

    // Count above the lane limit together with a positive scale.
    set_config(3'd7, {16'hFFFF, 16'h0001, 16'hC000, 16'h4000}, 24'h7FFFFF);
    send_pair(make_pair({16'h0800, 16'hF800, 16'h0400, 16'h1000}, '0, 16'h8000));
    send_pair(make_pair({4{16'h7FFF}}, {4{16'h8000}}, 16'h8000));
    send_pair(make_pair({16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE}, '0, 16'h7FFF));

    set_config(3'd1, {16'h0000, 16'h0000, 16'h0000, 16'h4000}, 24'h000000);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED + 1, 32'h0000_0003);
    send_pair(make_pair({4{16'h7FFF}}, {4{16'h8000}}, 16'h8000));

    set_config(3'd1, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000}, gkg_pkg::NIS_RST);
    send_pair(make_pair({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1000}, '0, 16'h8000));
    send_pair(make_pair({16'h0000, 16'h0000, 16'h0000, 16'h8000}, '0, 16'h2000));

    set_config(3'd2, {16'h1000, 16'h2000, 16'hE000, 16'h4000}, 24'hFC0000);
    send_pair(make_pair({16'h0000, 16'h0000, 16'h3000, 16'h2000}, '0, 16'h6000));
    send_pair(make_pair({16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000}, '0, 16'h8000));

    set_config(3'd3, {16'h1000, 16'h2000, 16'hE000, 16'h4000}, 24'hFE0000);
    send_pair(make_pair({16'h0000, 16'h0400, 16'h0800, 16'hFC00}, '0, 16'h8000));
    send_pair(make_pair({16'h0000, 16'h8000, 16'h7FFF, 16'h0001},
                        {16'h0000, 16'h7FFF, 16'h8000, 16'h0000}, 16'h1000));

    set_config(3'd5, {16'h0100, 16'hFF00, 16'h0200, 16'hFE00}, gkg_pkg::NIS_RST);
    send_pair(make_pair({16'h0400, 16'h0400, 16'h0400, 16'h0400}, '0, 16'h8000));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int set = 0; set < 2; set++) begin
        random_config();
        repeat (SET_ITEMS) send_pair(random_pair());
      end
    end

    drain();
    if (board.errors == 0 && board.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
